// File: design/gcc_pkg.sv
// shared types, constants and helper functions for the circular geofence check
// no dependencies; imported by gcc_serial_unit and geofence_circle_check
package gcc_pkg;

	// arithmetic unit operations
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// product shift selects (floor(a*b / 2^s))
	localparam logic [1:0] SH60 = 2'd0;
	localparam logic [1:0] SH36 = 2'd1;
	localparam logic [1:0] SH35 = 2'd2;

	// result status codes
	localparam logic [1:0] ST_NOHIT  = 2'd0;
	localparam logic [1:0] ST_HIT    = 2'd1;
	localparam logic [1:0] ST_STORED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// fixed point constants, Q60 unsigned
	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
	localparam logic [63:0] HALF_PI = PI_Q60 >> 1;
	localparam logic [27:0] TURN_DIV = 28'd225000000;
	localparam logic [63:0] TURN_RND = 64'd112500000;
	localparam logic [27:0] EARTH_R  = 28'd6371000;
	localparam logic [3:0]  SERIES_STEPS = 4'd12;
	localparam logic [35:0] HALF_TURN = 36'h800000000;
	localparam logic [35:0] QTR_TURN  = 36'h400000000;

	// control bundle to the serial arithmetic unit
	typedef struct packed {
		logic       start;
		logic       op;
		logic [1:0] shsel;
	} gcc_ctl_t;

	// sine series divisor (2k)(2k+1)
	function automatic logic [27:0] sin_div(input logic [3:0] k);
		logic [11:0] tk;
		tk = {7'd0, k, 1'b0};
		return 28'(tk * (tk + 12'd1));
	endfunction

	// cosine series divisor (2k-1)(2k)
	function automatic logic [27:0] cos_div(input logic [3:0] k);
		logic [11:0] tk;
		tk = {7'd0, k, 1'b0};
		return 28'(tk * (tk - 12'd1));
	endfunction

	// fold a turn angle onto [0, half turn]
	function automatic logic [35:0] fold36(input logic [35:0] t);
		return (t > HALF_TURN) ? 36'd0 - t : t;
	endfunction

	// clamp a signed Q60 value to [0, 1]
	function automatic logic [60:0] clamp_unit(input logic signed [63:0] v);
		if (v[63])
			return 61'd0;
		else if (v > $signed(ONE_Q60))
			return ONE_Q60[60:0];
		else
			return v[60:0];
	endfunction

	// built-in zone centres and radii
	function automatic logic [30:0] bi_lat(input logic [1:0] i);
		case (i)
			2'd0:    return 31'd336167000;
			2'd1:    return 31'd335987000;
			default: return 31'd337294000;
		endcase
	endfunction

	function automatic logic [31:0] bi_lon(input logic [1:0] i);
		case (i)
			2'd0:    return 32'd730997000;
			2'd1:    return 32'd730551000;
			default: return 32'd730931000;
		endcase
	endfunction

	function automatic logic [24:0] bi_rad(input logic [1:0] i);
		case (i)
			2'd0:    return 25'd5000;
			2'd1:    return 25'd2000;
			default: return 25'd1500;
		endcase
	endfunction

endpackage

// File: design/gcc_serial_unit.sv
// bit-serial 64x64 multiplier and 96-by-28 bit restoring divider, one bit per cycle
// depends on gcc_pkg
module gcc_serial_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  gcc_pkg::gcc_ctl_t ctl,
	input  logic [63:0]       op_a,
	input  logic [63:0]       op_b,
	input  logic [95:0]       dvd,
	input  logic [27:0]       dvsr,
	output logic [63:0]       res,
	output logic              done
);
	import gcc_pkg::*;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        op_q;
	logic [1:0]  sh_q;
	logic [63:0] hi_q;
	logic [95:0] lo_q;
	logic [63:0] a_q;
	logic [27:0] rem_q;

	logic [64:0]  sum;
	logic [28:0]  rn;
	logic         ge;
	logic [127:0] prod;
	logic [6:0]   last;

	// one step of either operation
	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
	assign rn   = {rem_q, lo_q[95]};
	assign ge   = rn >= {1'b0, a_q[27:0]};
	assign prod = {hi_q, lo_q[63:0]};
	assign last = (op_q == OP_MUL) ? 7'd63 : 7'd95;
	assign done = busy_q && (cnt_q == last);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (done)
				busy_q <= 1'b0;
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q  <= ctl.op;
			sh_q  <= ctl.shsel;
			hi_q  <= '0;
			rem_q <= '0;
			if (ctl.op == OP_MUL) begin
				a_q  <= op_a;
				lo_q <= {32'd0, op_b};
			end else begin
				a_q  <= {36'd0, dvsr};
				lo_q <= dvd;
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				hi_q <= sum[64:1];
				lo_q <= {32'd0, sum[0], lo_q[63:1]};
			end else begin
				rem_q <= ge ? 28'(rn - {1'b0, a_q[27:0]}) : rn[27:0];
				lo_q  <= {lo_q[94:0], ge};
			end
		end
	end

	// result select
	always_comb begin
		if (op_q == OP_DIV) begin
			res = lo_q[63:0];
		end else begin
			case (sh_q)
				SH36:    res = prod[99:36];
				SH35:    res = prod[98:35];
				default: res = prod[123:60];
			endcase
		end
	end

endmodule

// File: design/geofence_circle_check.sv
// top level of the circular geofence check: zone table, sequencer and datapath registers
// depends on gcc_pkg and gcc_serial_unit
//
// Input channel (in_valid/in_ready): one beat carries mode, latitude, longitude and
// radius_m. Mode 0 appends a zone to the table; mode 1 tests a position against the
// stored zones in insertion order. Output channel (out_valid/out_ready): one beat per
// input beat with status and zone_index.
// An add goes through S_FIN, which loads its result into the output register once
// that register is free. A query first converts the position, then tests each
// zone until the first hit (less work for a zone whose radius reaches half the
// circumference); every multiply and every divide runs in the single shared
// bit-serial multiply/divide unit, and each zone needs four sine/cosine series
// of 25 multiplies and 24 divides.
// in_ready is high only while no item is being worked on. A finished result waits in
// the output register; a new item is accepted meanwhile, and its result is held
// until the previous one has been taken.
// Reset empties the output register and restores the table to the three built-in
// zones (zone count 3). The zone memory needs no clearing pass: built-in entries
// come from constants and other slots are read only after they are written.
module geofence_circle_check #(
	parameter int MAX_ZONES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [30:0] latitude,
	input  logic [31:0] longitude,
	input  logic [24:0] radius_m,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  zone_index
);
	import gcc_pkg::*;

	localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int CW = $clog2(MAX_ZONES + 1);
	localparam int ZW = (IW > 4) ? IW : 4;
	localparam int MW = 31 + 32 + 25;

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_WAIT    = 6'd1;
	localparam logic [5:0] S_FIN     = 6'd2;
	localparam logic [5:0] S_PLAT    = 6'd3;
	localparam logic [5:0] S_PLAT_R  = 6'd4;
	localparam logic [5:0] S_PLON    = 6'd5;
	localparam logic [5:0] S_PLON_R  = 6'd6;
	localparam logic [5:0] S_PC      = 6'd7;
	localparam logic [5:0] S_PC_R    = 6'd8;
	localparam logic [5:0] S_PC_D    = 6'd9;
	localparam logic [5:0] S_ZRD     = 6'd10;
	localparam logic [5:0] S_ZRD2    = 6'd11;
	localparam logic [5:0] S_ZLAT    = 6'd12;
	localparam logic [5:0] S_ZLAT_R  = 6'd13;
	localparam logic [5:0] S_ZLON    = 6'd14;
	localparam logic [5:0] S_ZLON_R  = 6'd15;
	localparam logic [5:0] S_ZC      = 6'd16;
	localparam logic [5:0] S_ZC_R    = 6'd17;
	localparam logic [5:0] S_ZC_D    = 6'd18;
	localparam logic [5:0] S_S1      = 6'd19;
	localparam logic [5:0] S_S1_R    = 6'd20;
	localparam logic [5:0] S_S1_D    = 6'd21;
	localparam logic [5:0] S_S2      = 6'd22;
	localparam logic [5:0] S_S2_R    = 6'd23;
	localparam logic [5:0] S_S2_D    = 6'd24;
	localparam logic [5:0] S_P1      = 6'd25;
	localparam logic [5:0] S_P1_R    = 6'd26;
	localparam logic [5:0] S_P2      = 6'd27;
	localparam logic [5:0] S_P2_R    = 6'd28;
	localparam logic [5:0] S_P3      = 6'd29;
	localparam logic [5:0] S_P3_R    = 6'd30;
	localparam logic [5:0] S_A       = 6'd31;
	localparam logic [5:0] S_A_R     = 6'd32;
	localparam logic [5:0] S_TH      = 6'd33;
	localparam logic [5:0] S_TH_R    = 6'd34;
	localparam logic [5:0] S_TS_D    = 6'd35;
	localparam logic [5:0] S_T_R     = 6'd36;
	localparam logic [5:0] SC_X2     = 6'd37;
	localparam logic [5:0] SC_X2_R   = 6'd38;
	localparam logic [5:0] SC_TS     = 6'd39;
	localparam logic [5:0] SC_TS_R   = 6'd40;
	localparam logic [5:0] SC_TS_D   = 6'd41;
	localparam logic [5:0] SC_TC     = 6'd42;
	localparam logic [5:0] SC_TC_R   = 6'd43;
	localparam logic [5:0] SC_TC_D   = 6'd44;

	// control state
	logic [5:0]    state_q;
	logic [5:0]    wret_q;
	logic [5:0]    scret_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] zi_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [3:0]    zone_index_q;

	// payload registers
	logic [30:0]   lat_q;
	logic [31:0]   lon_q;
	logic [1:0]    rst_q;
	logic [3:0]    ridx_q;
	logic [35:0]   plat_q, plon_q, zlt_q, zln_q;
	logic [60:0]   pc_q, zc_q, s1_q, s2_q, a_q, sc_s_q, sc_c_q;
	logic          pneg_q, zneg_q;
	logic [30:0]   zlat_q;
	logic [31:0]   zlon_q;
	logic [24:0]   zrad_q;
	logic [63:0]   t1_q, t2_q, p_q;
	logic [63:0]   sc_x_q, x2_q, ts_q, tc_q;
	logic signed [63:0] ss_q, cs_q;
	logic [3:0]    k_q;

	// zone memory
	logic [MW-1:0] mem [MAX_ZONES];
	logic [MW-1:0] mem_rd_q;

	// arithmetic unit
	gcc_ctl_t    ctl;
	logic [63:0] op_a, op_b, res;
	logic [95:0] dvd;
	logic [27:0] dvsr;
	logic        u_done;

	gcc_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.dvd    (dvd),
		.dvsr   (dvsr),
		.res    (res),
		.done   (u_done)
	);

	// angle to turns: dividend of the rounding divide
	function automatic logic [95:0] turn_dvd(input logic [31:0] v);
		logic [31:0] mag;
		mag = v[31] ? 32'd0 - v : v;
		return {32'd0, {mag, 32'd0} + TURN_RND};
	endfunction

	function automatic logic [35:0] turn_fix(input logic [63:0] q, input logic neg);
		return neg ? 36'd0 - q[35:0] : q[35:0];
	endfunction

	// latitude cosine argument and sign
	logic [35:0] lc_in, lc_f, lc_m;
	logic        lc_neg;
	assign lc_in  = (state_q == S_PC || state_q == S_PC_R) ? plat_q : zlt_q;
	assign lc_f   = fold36(lc_in);
	assign lc_neg = lc_f > QTR_TURN;
	assign lc_m   = lc_neg ? HALF_TURN - lc_f : lc_f;

	// half angle differences
	logic [35:0] d_lat, d_lon;
	assign d_lat = fold36(zlt_q - plat_q);
	assign d_lon = fold36(zln_q - plon_q);

	// series sums after the current term
	logic signed [63:0] ss_nxt, cs_nxt;
	assign ss_nxt = k_q[0] ? ss_q - $signed(res) : ss_q + $signed(res);
	assign cs_nxt = k_q[0] ? cs_q - $signed(res) : cs_q + $signed(res);

	// haversine sum before clamping
	logic signed [63:0] a_sum;
	assign a_sum = (pneg_q != zneg_q) ? $signed(res) - $signed(p_q)
	                                  : $signed(res) + $signed(p_q);

	// operands for the arithmetic unit
	always_comb begin
		ctl  = '0;
		op_a = '0;
		op_b = '0;
		dvd  = '0;
		dvsr = TURN_DIV;
		case (state_q)
			S_PLAT: begin
				ctl = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd = turn_dvd({lat_q[30], lat_q});
			end
			S_PLON: begin
				ctl = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd = turn_dvd(lon_q);
			end
			S_ZLAT: begin
				ctl = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd = turn_dvd({zlat_q[30], zlat_q});
			end
			S_ZLON: begin
				ctl = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd = turn_dvd(zlon_q);
			end
			S_PC, S_ZC: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH35};
				op_a = {28'd0, lc_m};
				op_b = PI_Q60;
			end
			S_S1: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH36};
				op_a = {28'd0, d_lat};
				op_b = PI_Q60;
			end
			S_S2: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH36};
				op_a = {28'd0, d_lon};
				op_b = PI_Q60;
			end
			S_P1: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = {3'd0, pc_q};
				op_b = {3'd0, zc_q};
			end
			S_P2: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = {3'd0, s2_q};
				op_b = {3'd0, s2_q};
			end
			S_P3: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = t1_q;
				op_b = t2_q;
			end
			S_A: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = {3'd0, s1_q};
				op_b = {3'd0, s1_q};
			end
			S_TH: begin
				ctl  = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd  = {12'd0, zrad_q, 59'd0};
				dvsr = EARTH_R;
			end
			S_TS_D: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = {3'd0, sc_s_q};
				op_b = {3'd0, sc_s_q};
			end
			SC_X2: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = sc_x_q;
				op_b = sc_x_q;
			end
			SC_TS: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = ts_q;
				op_b = x2_q;
			end
			SC_TS_R: begin
				ctl  = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd  = {32'd0, res};
				dvsr = sin_div(k_q);
			end
			SC_TC: begin
				ctl  = '{start: 1'b1, op: OP_MUL, shsel: SH60};
				op_a = tc_q;
				op_b = x2_q;
			end
			SC_TC_R: begin
				ctl  = '{start: 1'b1, op: OP_DIV, shsel: SH60};
				dvd  = {32'd0, res};
				dvsr = cos_div(k_q);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// handshakes
	logic in_acc, fin_load;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign zone_index = zone_index_q;

	// add decision
	logic          has_room;
	logic [ZW-1:0] cnt_w, zi_w;
	assign has_room = cnt_q < CW'(MAX_ZONES);
	assign cnt_w    = ZW'(cnt_q);
	assign zi_w     = ZW'(zi_q);

	// zone memory write and registered read
	always_ff @(posedge clk) begin
		if (in_acc && !mode && has_room)
			mem[cnt_q[IW-1:0]] <= {latitude, longitude, radius_m};
		if (state_q == S_ZRD)
			mem_rd_q <= mem[zi_q[IW-1:0]];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			status_q     <= rst_q;
			zone_index_q <= ridx_q;
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wret_q  <= S_IDLE;
			scret_q <= S_IDLE;
			cnt_q   <= CW'(3);
			zi_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!mode) begin
							state_q <= S_FIN;
							if (has_room)
								cnt_q <= cnt_q + CW'(1);
						end else begin
							state_q <= S_PLAT;
						end
					end
				end
				S_WAIT: begin
					if (u_done)
						state_q <= wret_q;
				end
				S_FIN: begin
					if (fin_load)
						state_q <= S_IDLE;
				end
				S_PLAT: begin
					wret_q  <= S_PLAT_R;
					state_q <= S_WAIT;
				end
				S_PLAT_R: state_q <= S_PLON;
				S_PLON: begin
					wret_q  <= S_PLON_R;
					state_q <= S_WAIT;
				end
				S_PLON_R: state_q <= S_PC;
				S_PC: begin
					wret_q  <= S_PC_R;
					state_q <= S_WAIT;
				end
				S_PC_R: begin
					scret_q <= S_PC_D;
					state_q <= SC_X2;
				end
				S_PC_D: begin
					zi_q    <= '0;
					state_q <= S_ZRD;
				end
				S_ZRD:  state_q <= S_ZRD2;
				S_ZRD2: state_q <= S_ZLAT;
				S_ZLAT: begin
					wret_q  <= S_ZLAT_R;
					state_q <= S_WAIT;
				end
				S_ZLAT_R: state_q <= S_ZLON;
				S_ZLON: begin
					wret_q  <= S_ZLON_R;
					state_q <= S_WAIT;
				end
				S_ZLON_R: state_q <= S_ZC;
				S_ZC: begin
					wret_q  <= S_ZC_R;
					state_q <= S_WAIT;
				end
				S_ZC_R: begin
					scret_q <= S_ZC_D;
					state_q <= SC_X2;
				end
				S_ZC_D: state_q <= S_S1;
				S_S1: begin
					wret_q  <= S_S1_R;
					state_q <= S_WAIT;
				end
				S_S1_R: begin
					scret_q <= S_S1_D;
					state_q <= SC_X2;
				end
				S_S1_D: state_q <= S_S2;
				S_S2: begin
					wret_q  <= S_S2_R;
					state_q <= S_WAIT;
				end
				S_S2_R: begin
					scret_q <= S_S2_D;
					state_q <= SC_X2;
				end
				S_S2_D: state_q <= S_P1;
				S_P1: begin
					wret_q  <= S_P1_R;
					state_q <= S_WAIT;
				end
				S_P1_R: state_q <= S_P2;
				S_P2: begin
					wret_q  <= S_P2_R;
					state_q <= S_WAIT;
				end
				S_P2_R: state_q <= S_P3;
				S_P3: begin
					wret_q  <= S_P3_R;
					state_q <= S_WAIT;
				end
				S_P3_R: state_q <= S_A;
				S_A: begin
					wret_q  <= S_A_R;
					state_q <= S_WAIT;
				end
				S_A_R: state_q <= S_TH;
				S_TH: begin
					wret_q  <= S_TH_R;
					state_q <= S_WAIT;
				end
				S_TH_R: begin
					if (res >= HALF_PI) begin
						state_q <= S_FIN;
					end else begin
						scret_q <= S_TS_D;
						state_q <= SC_X2;
					end
				end
				S_TS_D: begin
					wret_q  <= S_T_R;
					state_q <= S_WAIT;
				end
				S_T_R: begin
					if ({3'd0, a_q} <= res) begin
						state_q <= S_FIN;
					end else if (zi_q + CW'(1) == cnt_q) begin
						state_q <= S_FIN;
					end else begin
						zi_q    <= zi_q + CW'(1);
						state_q <= S_ZRD;
					end
				end
				SC_X2: begin
					wret_q  <= SC_X2_R;
					state_q <= S_WAIT;
				end
				SC_X2_R: state_q <= SC_TS;
				SC_TS: begin
					wret_q  <= SC_TS_R;
					state_q <= S_WAIT;
				end
				SC_TS_R: begin
					wret_q  <= SC_TS_D;
					state_q <= S_WAIT;
				end
				SC_TS_D: state_q <= SC_TC;
				SC_TC: begin
					wret_q  <= SC_TC_R;
					state_q <= S_WAIT;
				end
				SC_TC_R: begin
					wret_q  <= SC_TC_D;
					state_q <= S_WAIT;
				end
				SC_TC_D: begin
					if (k_q == SERIES_STEPS)
						state_q <= scret_q;
					else
						state_q <= SC_TS;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					lat_q <= latitude;
					lon_q <= longitude;
					if (!mode) begin
						rst_q  <= has_room ? ST_STORED : ST_FULL;
						ridx_q <= has_room ? cnt_w[3:0] : 4'd0;
					end
				end
			end
			S_PLAT_R: plat_q <= turn_fix(res, lat_q[30]);
			S_PLON_R: plon_q <= turn_fix(res, lon_q[31]);
			S_PC_R: begin
				sc_x_q <= res;
				pneg_q <= lc_neg;
			end
			S_PC_D: pc_q <= sc_c_q;
			S_ZRD2: begin
				if (zi_q < CW'(3)) begin
					zlat_q <= bi_lat(zi_q[1:0]);
					zlon_q <= bi_lon(zi_q[1:0]);
					zrad_q <= bi_rad(zi_q[1:0]);
				end else begin
					{zlat_q, zlon_q, zrad_q} <= mem_rd_q;
				end
			end
			S_ZLAT_R: zlt_q <= turn_fix(res, zlat_q[30]);
			S_ZLON_R: zln_q <= turn_fix(res, zlon_q[31]);
			S_ZC_R: begin
				sc_x_q <= res;
				zneg_q <= lc_neg;
			end
			S_ZC_D: zc_q <= sc_c_q;
			S_S1_R, S_S2_R: sc_x_q <= res;
			S_S1_D: s1_q <= sc_s_q;
			S_S2_D: s2_q <= sc_s_q;
			S_P1_R: t1_q <= res;
			S_P2_R: t2_q <= res;
			S_P3_R: p_q  <= res;
			S_A_R:  a_q  <= clamp_unit(a_sum);
			S_TH_R: begin
				sc_x_q <= res;
				rst_q  <= ST_HIT;
				ridx_q <= zi_w[3:0];
			end
			S_T_R: begin
				if ({3'd0, a_q} <= res) begin
					rst_q  <= ST_HIT;
					ridx_q <= zi_w[3:0];
				end else begin
					rst_q  <= ST_NOHIT;
					ridx_q <= 4'd0;
				end
			end
			SC_X2_R: begin
				x2_q <= res;
				ts_q <= sc_x_q;
				tc_q <= ONE_Q60;
				ss_q <= $signed(sc_x_q);
				cs_q <= $signed(ONE_Q60);
				k_q  <= 4'd1;
			end
			SC_TS_D: begin
				ts_q <= res;
				ss_q <= ss_nxt;
			end
			SC_TC_D: begin
				tc_q <= res;
				cs_q <= cs_nxt;
				k_q  <= k_q + 4'd1;
				if (k_q == SERIES_STEPS) begin
					sc_s_q <= clamp_unit(ss_q);
					sc_c_q <= clamp_unit(cs_nxt);
				end
			end
			default: begin
			end
		endcase
	end

	// the serial unit only finishes while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == S_WAIT)
		else $error("arithmetic unit finished outside wait state");

	// the zone walk never points past the stored zones
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ZRD |-> zi_q < cnt_q)
		else $error("zone walk index beyond zone count");

	// an add grows the table by one unless it is full
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !mode) |=> (cnt_q == $past(cnt_q) + CW'(1)) ||
			($past(cnt_q) == CW'(MAX_ZONES) && cnt_q == $past(cnt_q)))
		else $error("zone count did not follow the add");

endmodule

// File: test/tb.sv
// self-checking testbench for geofence_circle_check: zone adds and position queries
// depends on gcc_pkg and the geofence_circle_check rtl; holds its own distance predictor
`timescale 1ns / 1ps

// zone table model and expected-result store
class zone_scoreboard;
	localparam int ZONES = 16;
	localparam logic [63:0] EARTH_M = 64'd6371000;
	localparam logic [63:0] TURN_MASK = (64'd1 << 36) - 64'd1;

	logic signed [30:0] zlat [ZONES];
	logic signed [31:0] zlon [ZONES];
	logic [24:0] zrad [ZONES];
	int zcount;
	logic [1:0] exp_status [$];
	logic [3:0] exp_index [$];
	int errors;

	function new();
		for (int i = 0; i < ZONES; i++) begin
			zlat[i] = '0;
			zlon[i] = '0;
			zrad[i] = '0;
		end
		zlat[0] = 31'sd336167000; zlon[0] = 32'sd730997000; zrad[0] = 25'd5000;
		zlat[1] = 31'sd335987000; zlon[1] = 32'sd730551000; zrad[1] = 25'd2000;
		zlat[2] = 31'sd337294000; zlon[2] = 32'sd730931000; zrad[2] = 25'd1500;
		zcount = 3;
		errors = 0;
	endfunction

	// floor(a*b / 2^s), low 64 bits
	function logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> s);
	endfunction

	function logic [63:0] sat_unit(longint v);
		if (v < 0)
			return 64'd0;
		if (v > longint'(gcc_pkg::ONE_Q60))
			return gcc_pkg::ONE_Q60;
		return 64'(v);
	endfunction

	// truncated taylor series of sine and cosine
	function void series(logic [63:0] x, output logic [63:0] s, output logic [63:0] c);
		logic [63:0] x2, ts, tc;
		longint ss, cs;
		x2 = prod_shift(x, x, 60);
		ts = x;
		tc = gcc_pkg::ONE_Q60;
		ss = longint'(x);
		cs = longint'(gcc_pkg::ONE_Q60);
		for (int k = 1; k <= 12; k++) begin
			ts = prod_shift(ts, x2, 60) / 64'((2 * k) * (2 * k + 1));
			tc = prod_shift(tc, x2, 60) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				ss -= longint'(ts);
				cs -= longint'(tc);
			end else begin
				ss += longint'(ts);
				cs += longint'(tc);
			end
		end
		s = sat_unit(ss);
		c = sat_unit(cs);
	endfunction

	// 1e-7 degree units to 2^-36 turns, ties away from zero
	function logic [63:0] turns(longint v);
		logic [63:0] mag, q;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		q = ((mag << 32) + 64'd112500000) / 64'd225000000;
		if (v < 0)
			q = 64'd0 - q;
		return q & TURN_MASK;
	endfunction

	function logic [63:0] fold_turn(logic [63:0] t);
		t &= TURN_MASK;
		return (t > (64'd1 << 35)) ? (64'd1 << 36) - t : t;
	endfunction

	function logic [63:0] sin_half(logic [63:0] t1, logic [63:0] t2);
		logic [63:0] s, c;
		series(prod_shift(fold_turn(t2 - t1), gcc_pkg::PI_Q60, 36), s, c);
		return s;
	endfunction

	function logic [63:0] cos_lat(logic [63:0] t, output bit neg);
		logic [63:0] m, s, c;
		m = fold_turn(t);
		neg = 0;
		if (m > (64'd1 << 34)) begin
			neg = 1;
			m = (64'd1 << 35) - m;
		end
		series(prod_shift(m, gcc_pkg::PI_Q60, 35), s, c);
		return c;
	endfunction

	function bit inside_radius(logic [24:0] r, logic [63:0] a);
		logic [127:0] num;
		logic [63:0] theta, s, c;
		num = {103'd0, r} << 59;
		theta = 64'(num / {64'd0, EARTH_M});
		if (theta >= (gcc_pkg::PI_Q60 >> 1))
			return 1;
		series(theta, s, c);
		return a <= prod_shift(s, s, 60);
	endfunction

	// accepted input beat: update the table and queue the expected result
	function void note_input(logic m, logic [30:0] la, logic [31:0] lo, logic [24:0] r);
		logic [63:0] plat, plon, pc, zc, zt, s1, s2, p;
		longint a;
		bit pneg, zneg;
		logic [1:0] st;
		logic [3:0] idx;
		st = gcc_pkg::ST_NOHIT;
		idx = 4'd0;
		if (m == 1'b0) begin
			if (zcount < ZONES) begin
				zlat[zcount] = la;
				zlon[zcount] = lo;
				zrad[zcount] = r;
				st = gcc_pkg::ST_STORED;
				idx = 4'(zcount);
				zcount++;
			end else begin
				st = gcc_pkg::ST_FULL;
			end
		end else begin
			plat = turns(longint'($signed(la)));
			plon = turns(longint'($signed(lo)));
			pc = cos_lat(plat, pneg);
			for (int i = 0; i < zcount; i++) begin
				zt = turns(longint'(zlat[i]));
				zc = cos_lat(zt, zneg);
				s1 = sin_half(plat, zt);
				s2 = sin_half(plon, turns(longint'(zlon[i])));
				p = prod_shift(prod_shift(pc, zc, 60), prod_shift(s2, s2, 60), 60);
				a = longint'(prod_shift(s1, s1, 60));
				a = (pneg != zneg) ? a - longint'(p) : a + longint'(p);
				if (inside_radius(zrad[i], sat_unit(a))) begin
					st = gcc_pkg::ST_HIT;
					idx = 4'(i);
					break;
				end
			end
		end
		exp_status.insert(exp_status.size(), st);
		exp_index.insert(exp_index.size(), idx);
	endfunction

	// accepted output beat: compare with the oldest expectation
	function void check_result(logic [1:0] st, logic [3:0] idx);
		logic [1:0] es;
		logic [3:0] ei;
		if (exp_status.size() == 0) begin
			$display("%0t: unexpected result beat status %0d zone_index %0d", $time, st, idx);
			errors++;
			return;
		end
		es = exp_status.pop_front();
		ei = exp_index.pop_front();
		if (st !== es) begin
			$display("%0t: status expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (idx !== ei) begin
			$display("%0t: zone_index expected %0d actual %0d", $time, ei, idx);
			errors++;
		end
	endfunction

	function int pending();
		return exp_status.size();
	endfunction
endclass

module tb;
	import gcc_pkg::*;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam longint CYCLE_LIMIT = 500_000_000;
	localparam int RANDOM_ITEMS = 555;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [30:0] latitude = '0;
	logic [31:0] longitude = '0;
	logic [24:0] radius_m = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] zone_index;

	int idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;
	zone_scoreboard zones = new();

	geofence_circle_check uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .latitude(latitude), .longitude(longitude), .radius_m(radius_m),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .zone_index(zone_index)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// beat monitor on both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			zones.note_input(mode, latitude, longitude, radius_m);
		if (arst_n && out_valid && out_ready)
			zones.check_result(status, zone_index);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// drive one input beat and hold it until accepted
	task automatic send_beat(logic m, logic [30:0] la, logic [31:0] lo, logic [24:0] r);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		latitude <= la;
		longitude <= lo;
		radius_m <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// query near a stored zone centre, mostly the built-in ones, or at a random position
	task automatic query_near_zone();
		int k, sel;
		sel = $urandom_range(99);
		if (sel < 60)
			k = $urandom_range(2);
		else
			k = $urandom_range(zones.zcount - 1);
		if (sel >= 85)
			send_beat(MODE_QUERY, 31'($urandom), $urandom, 25'($urandom));
		else
			send_beat(MODE_QUERY, 31'(zones.zlat[k] + $signed($urandom_range(600)) - 300),
				zones.zlon[k] + $signed($urandom_range(600)) - 300, 25'($urandom));
	endtask

	initial begin
		int lat_r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queries against the built-in zones
		send_beat(MODE_QUERY, 31'sd336167000, 32'sd730997000, 25'd0);
		send_beat(MODE_QUERY, 31'sd335987000, 32'sd730551000, 25'd0);
		send_beat(MODE_QUERY, 31'sd337294000, 32'sd730931000, 25'd0);
		send_beat(MODE_QUERY, 31'sd0, 32'sd0, 25'h1FFFFFF);
		send_beat(MODE_QUERY, 31'sd900000000, -32'sd1800000000, 25'd0);
		// out-of-range angles wrap
		send_beat(MODE_QUERY, 31'h40000000, 32'h7FFFFFFF, 25'd0);

		// adds: zero radius, poles, field extremes
		send_beat(MODE_ADD, 31'sd0, 32'sd0, 25'd0);
		send_beat(MODE_ADD, 31'sd900000000, 32'sd1800000000, 25'd20000000);
		send_beat(MODE_ADD, -31'sd900000000, -32'sd1800000000, 25'd1);
		send_beat(MODE_ADD, 31'h40000000, 32'h80000000, 25'd12345);
		send_beat(MODE_ADD, 31'h3FFFFFFF, 32'h7FFFFFFF, 25'd1000000);
		while (zones.zcount < 15) begin
			lat_r = $urandom_range(1800000000);
			send_beat(MODE_ADD, 31'(lat_r - 900000000),
				32'($urandom_range(2000000000) - 1000000000), 25'($urandom_range(50000)));
		end
		// huge radius contains everything
		send_beat(MODE_ADD, -31'sd450000000, 32'sd1234567, 25'h1FFFFFF);
		// table full
		send_beat(MODE_ADD, 31'sd1, 32'sd1, 25'd1);
		// exact centre of the zero-radius zone counts as inside
		send_beat(MODE_QUERY, 31'sd0, 32'sd0, 25'd0);
		send_beat(MODE_QUERY, 31'sd899990000, 32'sd5, 25'd0);
		send_beat(MODE_QUERY, -31'sd899000000, 32'sd900000000, 25'd0);

		// random part in idling phases
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n * 4 / RANDOM_ITEMS)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 45; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 45; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			if ($urandom_range(99) < 25)
				query_near_zone();
			else
				send_beat(MODE_ADD, 31'($urandom), $urandom, 25'($urandom));
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		// drain
		while (zones.pending() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (zones.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
